// File: hw/rtl/gsdc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gsdc_pkg
// shared types and constants of the gain scheduled distance control unit
// ----------------------------------------------------------------------------
package gsdc_pkg;

  // payload widths
  localparam int RANGE_W = 16;
  localparam int SPEED_W = 13;

  // configuration register widths
  localparam int WFIRST_W = 11;
  localparam int WEND_W   = 12;
  localparam int TARGET_W = 16;
  localparam int GAIN_W   = 12;
  localparam int RECIP_W  = 25;
  localparam int LIMIT_W  = 12;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 25;

  // reset values of the configuration registers
  localparam logic [WFIRST_W-1:0] WFIRST_RST = 11'd340;
  localparam logic [WEND_W-1:0]   WEND_RST   = 12'd360;
  localparam logic [TARGET_W-1:0] TARGET_RST = 16'd1000;
  localparam logic [GAIN_W-1:0]   GMIN_RST   = 12'd102;
  localparam logic [GAIN_W-1:0]   GMAX_RST   = 12'd1024;
  localparam logic [RECIP_W-1:0]  RECIP_RST  = 25'd16777;
  localparam logic [LIMIT_W-1:0]  LIMIT_RST  = 12'd200;

  // serial multiplier geometry: widest multiplicand is |delta| * |error|
  localparam int MUL_A_W   = GAIN_W + RANGE_W;
  localparam int MUL_B_W   = RECIP_W;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int MUL_CNT_W = $clog2(MUL_B_W);

  // fraction bits of span_recip and of the gain
  localparam int RECIP_FRAC = 24;
  localparam int GAIN_FRAC  = 10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_FIRST    = 3'd0,
    CFG_WINDOW_END      = 3'd1,
    CFG_TARGET_DISTANCE = 3'd2,
    CFG_GAIN_MIN        = 3'd3,
    CFG_GAIN_MAX        = 3'd4,
    CFG_SPAN_RECIP      = 3'd5,
    CFG_SPEED_LIMIT     = 3'd6
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_SCAN      = 3'd0,
    ST_PREP      = 3'd1,
    ST_MUL_DE    = 3'd2,
    ST_MUL_SPAN  = 3'd3,
    ST_MUL_GAIN  = 3'd4,
    ST_SEND      = 3'd5
  } state_e;

  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic               done;
    logic [MUL_P_W-1:0] product;
  } mul_rsp_t;

endpackage
`default_nettype wire

// File: hw/rtl/gsdc_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gsdc stream interfaces
// valid/ready channels for range samples in and speed commands out
// ----------------------------------------------------------------------------
interface gsdc_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] range_mm;
  logic        last_sample;

  modport source (output valid, output range_mm, output last_sample, input ready);
  modport sink   (input valid, input range_mm, input last_sample, output ready);
endinterface

interface gsdc_out_if;
  logic               valid;
  logic               ready;
  logic signed [12:0] speed_command;
  logic        [15:0] nearest_range;

  modport source (output valid, output speed_command, output nearest_range, input ready);
  modport sink   (input valid, input speed_command, input nearest_range, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/gsdc_serial_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gsdc_serial_mul
// unsigned shift-add multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
module gsdc_serial_mul (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire gsdc_pkg::mul_req_t req_i,
  output      gsdc_pkg::mul_rsp_t rsp_o
);
  import gsdc_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [MUL_CNT_W-1:0] cnt_q, cnt_d;
  logic [MUL_A_W-1:0]   a_q;
  logic [MUL_B_W-1:0]   b_q;
  logic [MUL_P_W-1:0]   acc_q;
  logic [MUL_A_W:0]     sum;

  // add the multiplicand into the upper part, then shift the accumulator right
  assign sum = {1'b0, acc_q[MUL_P_W-1:MUL_B_W]} + (b_q[0] ? {1'b0, a_q} : '0);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == MUL_CNT_W'(MUL_B_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q   <= req_i.a;
      b_q   <= req_i.b;
      acc_q <= '0;
    end else if (busy_q) begin
      b_q   <= b_q >> 1;
      acc_q <= {sum, acc_q[MUL_B_W-1:1]};
    end
  end

  assign rsp_o.done    = done_q;
  assign rsp_o.product = acc_q;

endmodule
`default_nettype wire

// File: hw/rtl/gain_scheduled_distance_control_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gain_scheduled_distance_control_unit
// gain scheduled proportional speed control from the nearest range in a scan
// ----------------------------------------------------------------------------
// usage
//   in_i carries one range word per sample with a last-of-scan flag. words
//   that are not last are taken one per cycle and only update the sample
//   index and the window minimum, so a scan streams in at full rate.
//   the last word of a scan starts the speed calculation: three products
//   (|delta|*|error|, times span_recip, gain times |error|) run one after
//   another on a single bit-serial shift-add multiplier. the result word
//   is loaded into out_o in the send state; in_i.ready is low from the
//   last word until then. out_o is a registered stage: a waiting result
//   does not stop the next scan's samples, only a second result waits (in
//   the send state) until the receiver takes the first. configuration is
//   written through cfg_we_i/cfg_idx_i/cfg_data_i; the user writes it
//   only while the block is idle, which the block itself does not enforce;
//   unknown indexes are ignored. reset restores the configuration defaults,
//   clears the sample index, sets the minimum to full scale and drops any
//   pending result.
// ----------------------------------------------------------------------------
module gain_scheduled_distance_control_unit #(
  parameter int MAX_SAMPLES = 2048
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  gsdc_in_if.sink                               in_i,
  gsdc_out_if.source                            out_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [gsdc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [gsdc_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import gsdc_pkg::*;

  // sample index width and the width used for window compares
  localparam int IDX_W = $clog2(MAX_SAMPLES);
  localparam int CMP_W = (IDX_W > WEND_W) ? IDX_W : WEND_W;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_SAMPLES - 1);

  // configuration registers
  logic [WFIRST_W-1:0] window_first_q;
  logic [WEND_W-1:0]   window_end_q;
  logic [TARGET_W-1:0] target_q;
  logic [GAIN_W-1:0]   gain_min_q;
  logic [GAIN_W-1:0]   gain_max_q;
  logic [RECIP_W-1:0]  span_recip_q;
  logic [LIMIT_W-1:0]  speed_limit_q;

  // scan state
  state_e             state_q, state_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [RANGE_W-1:0] min_q, min_d;
  logic [RANGE_W-1:0] min_next;
  logic               in_acc;
  logic               in_window;

  // calculation registers
  logic [RANGE_W-1:0] min_res_q;
  logic [RANGE_W-1:0] abs_e_q;
  logic               e_neg_q;
  logic [GAIN_W-1:0]  abs_d_q;
  logic               d_neg_q;
  logic [SPEED_W-1:0] speed_q;

  // output stage
  logic               out_valid_q, out_valid_d;
  logic [SPEED_W-1:0] out_speed_q;
  logic [RANGE_W-1:0] out_near_q;
  logic               out_free;

  // fsm outputs
  logic     in_ready;
  logic     cap_prep;
  logic     cap_speed;
  logic     out_load;
  mul_req_t mul_req;
  mul_rsp_t mul_rsp;

  // datapath
  logic [RANGE_W:0]   e_full;
  logic [RANGE_W-1:0] abs_e;
  logic [GAIN_W:0]    d_full;
  logic [GAIN_W-1:0]  abs_d;
  logic [MUL_P_W-RECIP_FRAC-1:0] mag;
  logic               mag_big;
  logic               mag_gt_d;
  logic               mag_lt_d;
  logic [GAIN_W-1:0]  gain;
  logic [MUL_A_W-GAIN_FRAC-1:0] smag;
  logic [LIMIT_W-1:0] smag_lim;
  logic [SPEED_W-1:0] speed;

  // ---------------------------------------------------------------------------
  // configuration writes
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_first_q <= WFIRST_RST;
      window_end_q   <= WEND_RST;
      target_q       <= TARGET_RST;
      gain_min_q     <= GMIN_RST;
      gain_max_q     <= GMAX_RST;
      span_recip_q   <= RECIP_RST;
      speed_limit_q  <= LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_WINDOW_FIRST:    window_first_q <= cfg_data_i[WFIRST_W-1:0];
        CFG_WINDOW_END:      window_end_q   <= cfg_data_i[WEND_W-1:0];
        CFG_TARGET_DISTANCE: target_q       <= cfg_data_i[TARGET_W-1:0];
        CFG_GAIN_MIN:        gain_min_q     <= cfg_data_i[GAIN_W-1:0];
        CFG_GAIN_MAX:        gain_max_q     <= cfg_data_i[GAIN_W-1:0];
        CFG_SPAN_RECIP:      span_recip_q   <= cfg_data_i[RECIP_W-1:0];
        CFG_SPEED_LIMIT:     speed_limit_q  <= cfg_data_i[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // sample index and window minimum
  // ---------------------------------------------------------------------------
  assign in_acc    = in_i.valid && in_ready;
  assign in_window = (CMP_W'(idx_q) >= CMP_W'(window_first_q)) &&
                     (CMP_W'(idx_q) <  CMP_W'(window_end_q));
  assign min_next  = (in_window && (in_i.range_mm < min_q)) ? in_i.range_mm : min_q;

  always_comb begin
    idx_d = idx_q;
    min_d = min_q;
    if (in_acc) begin
      if (in_i.last_sample) begin
        // scan done: back to the start of a fresh scan
        idx_d = '0;
        min_d = '1;
      end else begin
        min_d = min_next;
        if (idx_q != IDX_LAST) begin
          idx_d = idx_q + 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // error and gain span, signed differences folded to sign and magnitude
  // ---------------------------------------------------------------------------
  assign e_full = {1'b0, min_res_q} - {1'b0, target_q};
  assign abs_e  = e_full[RANGE_W] ? RANGE_W'(-e_full) : e_full[RANGE_W-1:0];
  assign d_full = {1'b0, gain_max_q} - {1'b0, gain_min_q};
  assign abs_d  = d_full[GAIN_W] ? GAIN_W'(-d_full) : d_full[GAIN_W-1:0];

  // scheduled gain: only the compare of the scaled error with |delta| matters,
  // since both clamps land on one of the bounds once it is passed
  assign mag      = mul_rsp.product[MUL_P_W-1:RECIP_FRAC];
  assign mag_big  = |mag[MUL_P_W-RECIP_FRAC-1:GAIN_W];
  assign mag_gt_d = mag_big || (mag[GAIN_W-1:0] > abs_d_q);
  assign mag_lt_d = !mag_big && (mag[GAIN_W-1:0] < abs_d_q);

  always_comb begin
    if (d_neg_q) begin
      // reversed bounds: gain_max until the scaled error reaches |delta|, then gain_min
      gain = mag_lt_d ? gain_max_q : gain_min_q;
    end else begin
      gain = mag_gt_d ? gain_max_q : gain_min_q + mag[GAIN_W-1:0];
    end
  end

  // speed magnitude, limited, then signed by the error
  assign smag     = mul_rsp.product[MUL_A_W-1:GAIN_FRAC];
  assign smag_lim = (smag > (MUL_A_W-GAIN_FRAC)'(speed_limit_q)) ? speed_limit_q
                                                               : smag[LIMIT_W-1:0];
  assign speed    = e_neg_q ? SPEED_W'(-{1'b0, smag_lim}) : SPEED_W'({1'b0, smag_lim});

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  assign out_free = !out_valid_q || out_o.ready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_SCAN: begin
        if (in_acc && in_i.last_sample) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        state_d = ST_MUL_DE;
      end
      ST_MUL_DE: begin
        if (mul_rsp.done) begin
          state_d = ST_MUL_SPAN;
        end
      end
      ST_MUL_SPAN: begin
        if (mul_rsp.done) begin
          state_d = ST_MUL_GAIN;
        end
      end
      ST_MUL_GAIN: begin
        if (mul_rsp.done) begin
          state_d = ST_SEND;
        end
      end
      ST_SEND: begin
        if (out_free) begin
          state_d = ST_SCAN;
        end
      end
      default: state_d = ST_SCAN;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    cap_prep  = 1'b0;
    cap_speed = 1'b0;
    out_load  = 1'b0;
    mul_req   = '0;
    unique case (state_q)
      ST_SCAN: begin
        in_ready = 1'b1;
      end
      ST_PREP: begin
        // |delta| * |error|
        cap_prep      = 1'b1;
        mul_req.start = 1'b1;
        mul_req.a     = MUL_A_W'(abs_e);
        mul_req.b     = MUL_B_W'(abs_d);
      end
      ST_MUL_DE: begin
        // times span_recip
        mul_req.start = mul_rsp.done;
        mul_req.a     = mul_rsp.product[MUL_A_W-1:0];
        mul_req.b     = span_recip_q;
      end
      ST_MUL_SPAN: begin
        // scheduled gain times |error|
        mul_req.start = mul_rsp.done;
        mul_req.a     = MUL_A_W'(abs_e_q);
        mul_req.b     = MUL_B_W'(gain);
      end
      ST_MUL_GAIN: begin
        cap_speed = mul_rsp.done;
      end
      ST_SEND: begin
        out_load = out_free;
      end
      default: ;
    endcase
  end

  gsdc_serial_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  // ---------------------------------------------------------------------------
  // output stage
  // ---------------------------------------------------------------------------
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SCAN;
      idx_q       <= '0;
      min_q       <= '1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      min_q       <= min_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && in_i.last_sample) begin
      min_res_q <= min_next;
    end
    if (cap_prep) begin
      abs_e_q <= abs_e;
      e_neg_q <= e_full[RANGE_W];
      abs_d_q <= abs_d;
      d_neg_q <= d_full[GAIN_W];
    end
    if (cap_speed) begin
      speed_q <= speed;
    end
    if (out_load) begin
      out_speed_q <= speed_q;
      out_near_q  <= min_res_q;
    end
  end

  assign in_i.ready          = in_ready;
  assign out_o.valid         = out_valid_q;
  assign out_o.speed_command = out_speed_q;
  assign out_o.nearest_range = out_near_q;

endmodule
`default_nettype wire

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the gain scheduled distance control unit: range
// words stream in as scans, an in-bench model of the window minimum and the
// scheduled gain predicts each speed word that is not pinned by hand, and
// every word that comes out is compared field by field
// ----------------------------------------------------------------------------
module testbench;
  import gsdc_pkg::*;

  localparam int MAX_SAMPLES   = 2048;
  localparam int SETTLE_CYCLES = 8;     // block idle again once its result has left
  localparam int TAIL_CYCLES   = 100;   // a little over the speed latency
  localparam int STALL_LIMIT   = 2000;  // quiet cycles before the run is declared hung
  localparam int IDLE_PCT      = 13;

  typedef enum logic {ROW_WORD, ROW_REG} row_kind_e;

  // one speed word as the block should present it
  typedef struct packed {
    logic signed [SPEED_W-1:0] speed;
    logic [RANGE_W-1:0]        nearest;
  } speed_word_t;

  // directed row: either a range word (optionally with a result read off by
  // hand) or a register write
  typedef struct packed {
    row_kind_e                 kind;
    logic [RANGE_W-1:0]        range_mm;
    logic                      last_sample;
    logic                      pinned;
    logic signed [SPEED_W-1:0] speed;
    logic [RANGE_W-1:0]        nearest;
    cfg_reg_e                  reg_idx;
    logic [CFG_DATA_W-1:0]     reg_val;
  } dir_row_t;

  localparam int DIR_ROWS = 39;
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    // straight after reset the window 340..359 is never reached: full scale
    '{ROW_WORD, 16'd500,   1'b1, 1'b1,  13'sd200,  16'd65535, CFG_WINDOW_FIRST, 25'd0},
    '{ROW_REG,  16'd0,     1'b0, 1'b0,  13'sd0,    16'd0,     CFG_WINDOW_FIRST, 25'd0},
    '{ROW_REG,  16'd0,     1'b0, 1'b0,  13'sd0,    16'd0,     CFG_WINDOW_END,   25'd3},
    // zero range inside the window, far below target: negative limit
    '{ROW_WORD, 16'd0,     1'b0, 1'b0,  13'sd0,    16'd0,     CFG_WINDOW_FIRST, 25'd0},
    '{ROW_WORD, 16'd65535, 1'b0, 1'b0,  13'sd0,    16'd0,     CFG_WINDOW_FIRST, 25'd0},
    '{ROW_WORD, 16'd1000,  1'b1, 1'b1, -13'sd200,  16'd0,     CFG_WINDOW_FIRST, 25'd0},
    // exactly on target: zero error, zero speed
    '{ROW_WORD, 16'd1000,  1'b1, 1'b1,  13'sd0,    16'd1000,  CFG_WINDOW_FIRST, 25'd0},
    // no-return in the window leaves the minimum at full scale
    '{ROW_WORD, 16'd65535, 1'b1, 1'b1,  13'sd200,  16'd65535, CFG_WINDOW_FIRST, 25'd0},
    '{ROW_REG,  16'd0,     1'b0, 1'b0,  13'sd0,    16'd0,     CFG_SPEED_LIMIT,  25'd4095},
    '{ROW_REG,  16'd0,     1'b0, 1'b0,  13'sd0,    16'd0,     CFG_TARGET_DISTANCE, 25'd0},
    '{ROW_REG,  16'd0,     1'b0, 1'b0,  13'sd0,    16'd0,     CFG_GAIN_MIN,     25'd4095},
    '{ROW_REG,  16'd0,     1'b0, 1'b0,  13'sd0,    16'd0,     CFG_GAIN_MAX,     25'd4095},
    '{ROW_REG,  16'd0,     1'b0, 1'b0,  13'sd0,    16'd0,     CFG_SPAN_RECIP,   25'd0},
    // largest positive error with the largest gain and limit
    '{ROW_WORD, 16'd65535, 1'b1, 1'b1,  13'sd4095, 16'd65535, CFG_WINDOW_FIRST, 25'd0},
    '{ROW_REG,  16'd0,     1'b0, 1'b0,  13'sd0,    16'd0,     CFG_TARGET_DISTANCE, 25'd65535},
    // largest negative error
    '{ROW_WORD, 16'd0,     1'b1, 1'b1, -13'sd4095, 16'd0,     CFG_WINDOW_FIRST, 25'd0},
    // gain bounds reversed, full span reciprocal
    '{ROW_REG,  16'd0,     1'b0, 1'b0,  13'sd0,    16'd0,     CFG_GAIN_MAX,     25'd0},
    '{ROW_REG,  16'd0,     1'b0, 1'b0,  13'sd0,    16'd0,     CFG_SPAN_RECIP,   25'd16777216},
    '{ROW_REG,  16'd0,     1'b0, 1'b0,  13'sd0,    16'd0,     CFG_TARGET_DISTANCE, 25'd1000},
    '{ROW_WORD, 16'd1200,  1'b0, 1'b0,  13'sd0,    16'd0,     CFG_WINDOW_FIRST, 25'd0},
    '{ROW_WORD, 16'd900,   1'b1, 1'b0,  13'sd0,    16'd0,     CFG_WINDOW_FIRST, 25'd0},
    // widest span reciprocal, normal bounds
    '{ROW_REG,  16'd0,     1'b0, 1'b0,  13'sd0,    16'd0,     CFG_SPAN_RECIP,   25'd33554431},
    '{ROW_REG,  16'd0,     1'b0, 1'b0,  13'sd0,    16'd0,     CFG_GAIN_MIN,     25'd0},
    '{ROW_REG,  16'd0,     1'b0, 1'b0,  13'sd0,    16'd0,     CFG_GAIN_MAX,     25'd4095},
    '{ROW_WORD, 16'd2000,  1'b1, 1'b0,  13'sd0,    16'd0,     CFG_WINDOW_FIRST, 25'd0},
    // zero speed limit forces a zero command
    '{ROW_REG,  16'd0,     1'b0, 1'b0,  13'sd0,    16'd0,     CFG_SPEED_LIMIT,  25'd0},
    '{ROW_WORD, 16'd12345, 1'b1, 1'b1,  13'sd0,    16'd12345, CFG_WINDOW_FIRST, 25'd0},
    // scan ends before the window opens
    '{ROW_REG,  16'd0,     1'b0, 1'b0,  13'sd0,    16'd0,     CFG_SPEED_LIMIT,  25'd1500},
    '{ROW_REG,  16'd0,     1'b0, 1'b0,  13'sd0,    16'd0,     CFG_WINDOW_FIRST, 25'd5},
    '{ROW_REG,  16'd0,     1'b0, 1'b0,  13'sd0,    16'd0,     CFG_WINDOW_END,   25'd10},
    '{ROW_WORD, 16'd100,   1'b0, 1'b0,  13'sd0,    16'd0,     CFG_WINDOW_FIRST, 25'd0},
    '{ROW_WORD, 16'd200,   1'b0, 1'b0,  13'sd0,    16'd0,     CFG_WINDOW_FIRST, 25'd0},
    '{ROW_WORD, 16'd300,   1'b1, 1'b1,  13'sd1500, 16'd65535, CFG_WINDOW_FIRST, 25'd0},
    // window start past its end: nothing is ever searched
    '{ROW_REG,  16'd0,     1'b0, 1'b0,  13'sd0,    16'd0,     CFG_WINDOW_FIRST, 25'd2},
    '{ROW_REG,  16'd0,     1'b0, 1'b0,  13'sd0,    16'd0,     CFG_WINDOW_END,   25'd1},
    '{ROW_WORD, 16'd7,     1'b0, 1'b0,  13'sd0,    16'd0,     CFG_WINDOW_FIRST, 25'd0},
    '{ROW_WORD, 16'd8,     1'b0, 1'b0,  13'sd0,    16'd0,     CFG_WINDOW_FIRST, 25'd0},
    '{ROW_WORD, 16'd9,     1'b0, 1'b0,  13'sd0,    16'd0,     CFG_WINDOW_FIRST, 25'd0},
    '{ROW_WORD, 16'd10,    1'b1, 1'b1,  13'sd1500, 16'd65535, CFG_WINDOW_FIRST, 25'd0}
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  gsdc_in_if  in_if ();
  gsdc_out_if out_if ();

  gain_scheduled_distance_control_unit #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // shadow copy of the configuration registers
  logic [WFIRST_W-1:0] win_first;
  logic [WEND_W-1:0]   win_end;
  logic [TARGET_W-1:0] target;
  logic [GAIN_W-1:0]   gain_lo;
  logic [GAIN_W-1:0]   gain_hi;
  logic [RECIP_W-1:0]  recip;
  logic [LIMIT_W-1:0]  limit;

  // scan state as the block should hold it
  logic [WFIRST_W-1:0] scan_idx;
  logic [RANGE_W-1:0]  scan_min;

  speed_word_t speed_due_q [$];
  speed_word_t due;
  speed_word_t no_pin;

  bit idle_on;
  int words_sent;
  int speeds_checked;
  int reg_writes;
  int mismatches;
  int quiet_cycles;

  // 100 MHz clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // model of the block
  // ---------------------------------------------------------------------------

  function automatic void load_defaults();
    win_first = WFIRST_RST;
    win_end   = WEND_RST;
    target    = TARGET_RST;
    gain_lo   = GMIN_RST;
    gain_hi   = GMAX_RST;
    recip     = RECIP_RST;
    limit     = LIMIT_RST;
    scan_idx  = '0;
    scan_min  = '1;
  endfunction

  function automatic void shadow_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_WINDOW_FIRST:    win_first = val[WFIRST_W-1:0];
      CFG_WINDOW_END:      win_end   = val[WEND_W-1:0];
      CFG_TARGET_DISTANCE: target    = val[TARGET_W-1:0];
      CFG_GAIN_MIN:        gain_lo   = val[GAIN_W-1:0];
      CFG_GAIN_MAX:        gain_hi   = val[GAIN_W-1:0];
      CFG_SPAN_RECIP:      recip     = val[RECIP_W-1:0];
      CFG_SPEED_LIMIT:     limit     = val[LIMIT_W-1:0];
      default: ;
    endcase
  endfunction

  // gain moves with |error| from gain_lo toward gain_hi, then speed = gain * error, limited
  // all products stay below 2^54 so plain longint holds them exactly
  function automatic logic signed [SPEED_W-1:0] schedule_speed(input logic [RANGE_W-1:0] nearest);
    longint err, abs_err, delta, abs_delta, mag, gain, spd, lim;
    err       = longint'(nearest) - longint'(target);
    abs_err   = (err < 0) ? -err : err;
    delta     = longint'(gain_hi) - longint'(gain_lo);
    abs_delta = (delta < 0) ? -delta : delta;
    mag       = (abs_delta * abs_err * longint'(recip)) >> RECIP_FRAC;
    gain      = longint'(gain_lo) + ((delta < 0) ? -mag : mag);
    // upper bound is tested first, which matters when the bounds are reversed
    if (gain > longint'(gain_hi))
      gain = longint'(gain_hi);
    else if (gain < longint'(gain_lo))
      gain = longint'(gain_lo);
    mag = (gain * abs_err) >> GAIN_FRAC;
    spd = (err < 0) ? -mag : mag;
    lim = longint'(limit);
    if (spd > lim)
      spd = lim;
    else if (spd < -lim)
      spd = -lim;
    return spd[SPEED_W-1:0];
  endfunction

  // one accepted range word; a pinned result replaces the computed one
  function automatic void track_sample(input logic [RANGE_W-1:0] r, input logic last,
                                       input logic pinned, input speed_word_t pin);
    speed_word_t res;
    if (scan_idx >= win_first && scan_idx < win_end && r < scan_min)
      scan_min = r;
    // index saturates at the top so long scans keep counting as the last index
    if (scan_idx < WFIRST_W'(MAX_SAMPLES - 1))
      scan_idx = scan_idx + 1'b1;
    if (last) begin
      res.speed   = schedule_speed(scan_min);
      res.nearest = scan_min;
      speed_due_q.push_back(pinned ? pin : res);
      scan_idx = '0;
      scan_min = '1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  function automatic logic [RANGE_W-1:0] pick_range();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      // close to the set distance, so small errors of both signs appear
      2: return RANGE_W'(int'(target) + int'($urandom_range(0, 64)) - 32);
      default: return RANGE_W'($urandom());
    endcase
  endfunction

  task automatic send_word(input logic [RANGE_W-1:0] r, input logic last,
                           input logic pinned, input speed_word_t pin);
    cfg_we_i <= 1'b0;
    while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.range_mm    <= r;
    in_if.last_sample <= last;
    @(posedge clk_i);
    while (!in_if.ready)
      @(posedge clk_i);
    track_sample(r, last, pinned, pin);
    words_sent++;
  endtask

  // registers only change with the sender quiet and the block idle
  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    in_if.valid <= 1'b0;
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    shadow_reg(idx, val);
    reg_writes++;
  endtask

  // hold the sender until every speed word due has been taken
  task automatic drain();
    in_if.valid <= 1'b0;
    cfg_we_i    <= 1'b0;
    while (speed_due_q.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_random();
    logic [WFIRST_W-1:0] first;
    logic [WEND_W-1:0]   fin;
    logic [TARGET_W-1:0] tgt;
    logic [GAIN_W-1:0]   g_lo, g_hi;
    logic [RECIP_W-1:0]  span;
    logic [LIMIT_W-1:0]  lim;
    // small windows near the start of the scan keep scans short
    first = ($urandom_range(0, 7) == 0) ? WFIRST_W'($urandom_range(0, 2047))
                                        : WFIRST_W'($urandom_range(0, 24));
    case ($urandom_range(0, 7))
      0:       fin = '0;
      1:       fin = WEND_W'(MAX_SAMPLES);
      2:       fin = '1;
      default: fin = WEND_W'(first) + WEND_W'($urandom_range(0, 24));
    endcase
    case ($urandom_range(0, 7))
      0:       tgt = '0;
      1:       tgt = '1;
      2:       tgt = TARGET_W'($urandom());
      default: tgt = TARGET_W'($urandom_range(0, 3000));
    endcase
    case ($urandom_range(0, 5))
      0:       g_lo = '0;
      1:       g_lo = '1;
      default: g_lo = GAIN_W'($urandom());
    endcase
    case ($urandom_range(0, 5))
      0:       g_hi = '0;
      1:       g_hi = '1;
      default: g_hi = GAIN_W'($urandom());
    endcase
    case ($urandom_range(0, 7))
      0:       span = '0;
      1:       span = '1;
      2:       span = RECIP_W'(1 << RECIP_FRAC);
      3:       span = RECIP_W'($urandom());
      default: span = RECIP_W'($urandom_range(1, 65535));
    endcase
    case ($urandom_range(0, 7))
      0:       lim = '0;
      1:       lim = '1;
      2:       lim = LIMIT_W'(4000);
      default: lim = LIMIT_W'($urandom_range(0, 4000));
    endcase
    write_reg(CFG_WINDOW_FIRST, CFG_DATA_W'(first));
    write_reg(CFG_WINDOW_END, CFG_DATA_W'(fin));
    write_reg(CFG_TARGET_DISTANCE, CFG_DATA_W'(tgt));
    write_reg(CFG_GAIN_MIN, CFG_DATA_W'(g_lo));
    write_reg(CFG_GAIN_MAX, CFG_DATA_W'(g_hi));
    write_reg(CFG_SPAN_RECIP, CFG_DATA_W'(span));
    write_reg(CFG_SPEED_LIMIT, CFG_DATA_W'(lim));
  endtask

  // whole scans with random content, now and then waiting for the results
  task automatic run_scans(input int budget);
    int sent;
    int len;
    sent = 0;
    while (sent < budget) begin
      len = ($urandom_range(0, 15) == 0) ? $urandom_range(50, 300) : $urandom_range(1, 40);
      for (int k = 0; k < len; k++)
        send_word(pick_range(), k == len - 1, 1'b0, no_pin);
      sent += len;
      if ($urandom_range(0, 9) == 0)
        drain();
    end
  endtask

  // ---------------------------------------------------------------------------
  // receiver and checking
  // ---------------------------------------------------------------------------

  // receiver stalls at random while idling is on, else it is always ready
  always @(posedge clk_i)
    out_if.ready <= idle_on ? ($urandom_range(0, 99) >= IDLE_PCT) : 1'b1;

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (speed_due_q.size() == 0) begin
        mismatches++;
        $display("%0t ns: unexpected speed word: speed %0d nearest %0d", $time,
                 out_if.speed_command, out_if.nearest_range);
      end else begin
        due = speed_due_q.pop_front();
        speeds_checked++;
        if (out_if.speed_command !== due.speed) begin
          mismatches++;
          $display("%0t ns: speed_command expected %0d got %0d", $time,
                   due.speed, out_if.speed_command);
        end
        if (out_if.nearest_range !== due.nearest) begin
          mismatches++;
          $display("%0t ns: nearest_range expected %0d got %0d", $time,
                   due.nearest, out_if.nearest_range);
        end
      end
    end
  end

  // watchdog: any word moved or register written counts as progress
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || cfg_we_i)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t ns: no progress for %0d cycles, %0d speed words outstanding", $time,
               quiet_cycles, speed_due_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------

  initial begin
    dir_row_t    row;
    speed_word_t pin;
    bit          prev_word;

    clk_i             = 1'b0;
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_idx_i         = '0;
    cfg_data_i        = '0;
    in_if.valid       = 1'b0;
    in_if.range_mm    = '0;
    in_if.last_sample = 1'b0;
    out_if.ready      = 1'b0;
    idle_on           = 1'b1;
    no_pin            = '0;
    words_sent        = 0;
    speeds_checked    = 0;
    reg_writes        = 0;
    mismatches        = 0;
    quiet_cycles      = 0;
    prev_word         = 1'b0;
    load_defaults();

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table: extremes and corner cases
    for (int i = 0; i < DIR_ROWS; i++) begin
      row = DIR_TABLE[i];
      if (row.kind == ROW_REG) begin
        if (prev_word)
          drain();
        write_reg(row.reg_idx, row.reg_val);
        prev_word = 1'b0;
      end else begin
        pin.speed   = row.speed;
        pin.nearest = row.nearest;
        send_word(row.range_mm, row.last_sample, row.pinned, pin);
        prev_word = 1'b1;
      end
    end

    // random register settings, one of them run without any idling
    for (int p = 0; p < 12; p++) begin
      drain();
      idle_on = (p != 3);
      program_random();
      run_scans((p == 3) ? 300 : 95);
    end

    drain();
    idle_on = 1'b1;
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("summary: %0d range words sent, %0d speed words checked, %0d register writes",
             words_sent, speeds_checked, reg_writes);
    $display("summary: corner rows and 12 random settings, %0d mismatches",
             mismatches);
    if (mismatches == 0 && speed_due_q.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/gsdc_pkg.sv
hw/rtl/gsdc_if.sv
hw/rtl/gsdc_serial_mul.sv
hw/rtl/gain_scheduled_distance_control_unit.sv
sim/testbench.sv
